### design/voxel_segment_traversal_top_macros.svh
// Assertion macros used by the back end of the voxel segment traversal design.
`ifndef VOXEL_SEGMENT_TRAVERSAL_TOP_MACROS_SVH
`define VOXEL_SEGMENT_TRAVERSAL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define VST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define VST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define VST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VST_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### design/vst_pkg.sv
// Package with shared types, constants and helpers of the voxel segment traversal.
package vst_pkg;

  localparam int unsigned MaxCellsDef = 64;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned FracBitsMin = 8;
  localparam int unsigned FracBitsMax = 24;

  // Widths sized for the supported fraction settings: cells for the narrowest, numerators for the widest.
  localparam int unsigned CellW  = 34 - FracBitsMin + 1;
  localparam int unsigned NumW   = FracBitsMax + 1;
  localparam int unsigned DenW   = 34;
  localparam int unsigned DenHalf = DenW / 2;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned MulSteps = 12;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [15:0]              org;
    logic signed [CellW-1:0]  start_cell;
    logic [NumW-1:0]          num0;
    logic [DenW-1:0]          den;
    logic                     fin;
    logic                     neg;
  } vst_axis_t;

  typedef struct packed {
    vst_axis_t [2:0] axis;
  } vst_seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WALK
  } vst_state_e;

  // Cross products are kept as P[a][b] = num_a * den_b, six ordered pairs.
  localparam logic [2:0] P01 = 3'd0;
  localparam logic [2:0] P02 = 3'd1;
  localparam logic [2:0] P10 = 3'd2;
  localparam logic [2:0] P12 = 3'd3;
  localparam logic [2:0] P20 = 3'd4;
  localparam logic [2:0] P21 = 3'd5;

  function automatic logic [1:0] pair_a(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      P01, P02: r = 2'd0;
      P10, P12: r = 2'd1;
      default:  r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      P10, P20: r = 2'd0;
      P01, P21: r = 2'd1;
      default:  r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

### design/voxel_segment_traversal_top.sv
// Top level of the voxel segment traversal block.
// Each accepted segment yields every unit cell it passes through, start cell first and end
// cell last, one result per request; the walk stops after MAX_CELLS results and then flags
// truncation. A segment occupies the back end while it is loaded, while a single 25x17-bit
// multiplier builds the six exact cross products of the per-axis crossing times in twelve
// half-width steps, and while it walks, one cell per cycle unless the result waits for pop.
// Two classified segments can wait in the queue between front and back end.
module voxel_segment_traversal_top #(
  parameter int unsigned MAX_CELLS = vst_pkg::MaxCellsDef,
  parameter int unsigned FRAC_BITS = vst_pkg::FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] cell_x_o,
  output logic signed [15:0] cell_y_o,
  output logic signed [15:0] cell_z_o,
  output logic               last_o,
  output logic               truncated_o
);

  vst_pkg::vst_seg_t seg_in, seg_out;
  logic q_empty, q_rd;

  // Classification of the incoming request.
  vst_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .start_x_i(start_x_i), .start_y_i(start_y_i), .start_z_i(start_z_i),
    .end_x_i(end_x_i), .end_y_i(end_y_i), .end_z_i(end_z_i),
    .seg_o(seg_in)
  );

  vst_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .wr_i(push), .wdata_i(seg_in), .full_o(full),
    .rd_i(q_rd), .empty_o(q_empty), .rdata_o(seg_out)
  );

  vst_back #(.MAX_CELLS(MAX_CELLS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .q_empty_i(q_empty), .q_data_i(seg_out), .q_rd_o(q_rd),
    .empty(empty), .pop(pop),
    .cell_x_o(cell_x_o), .cell_y_o(cell_y_o), .cell_z_o(cell_z_o),
    .last_o(last_o), .truncated_o(truncated_o)
  );

endmodule

### design/vst_front.sv
// Front end: classifies each axis of an incoming segment relative to the end cell.
module vst_front #(
  parameter int unsigned FRAC_BITS = vst_pkg::FracBitsDef
) (
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  output vst_pkg::vst_seg_t  seg_o
);

  localparam logic [33:0] One  = 34'(1) << FRAC_BITS;
  localparam logic [33:0] Mask = One - 34'(1);

  logic signed [31:0] s_v [3];
  logic signed [31:0] e_v [3];

  assign s_v[0] = start_x_i;
  assign s_v[1] = start_y_i;
  assign s_v[2] = start_z_i;
  assign e_v[0] = end_x_i;
  assign e_v[1] = end_y_i;
  assign e_v[2] = end_z_i;

  // Each axis is worked out independently of the others.
  for (genvar g = 0; g < 3; g++) begin : g_axis
    logic signed [31:0] org;
    logic [33:0]        frac_e;
    logic signed [33:0] re;
    logic signed [33:0] rs;
    logic signed [34:0] dir;
    logic signed [33:0] cell_s;
    logic [33:0]        frac_s;

    always_comb begin
      org    = e_v[g] >>> FRAC_BITS;
      frac_e = 34'(e_v[g]) & Mask;
      // An end point on a boundary is nudged one step into its cell.
      re     = (frac_e == '0) ? 34'sd1 : signed'(frac_e);
      rs     = 34'(s_v[g]) - 34'(e_v[g]) + signed'(frac_e);
      dir    = 35'(re) - 35'(rs);
      cell_s = rs >>> FRAC_BITS;
      frac_s = unsigned'(rs) & Mask;
      seg_o.axis[g].org        = org[15:0];
      seg_o.axis[g].start_cell = vst_pkg::CellW'(cell_s);
      if (dir > 0) begin
        seg_o.axis[g].num0 = vst_pkg::NumW'(One - frac_s);
        seg_o.axis[g].den  = vst_pkg::DenW'(dir);
        seg_o.axis[g].fin  = 1'b1;
        seg_o.axis[g].neg  = 1'b0;
      end else if (dir < 0) begin
        seg_o.axis[g].num0 = vst_pkg::NumW'(frac_s);
        seg_o.axis[g].den  = vst_pkg::DenW'(-dir);
        seg_o.axis[g].fin  = 1'b1;
        seg_o.axis[g].neg  = 1'b1;
      end else begin
        seg_o.axis[g].num0 = '0;
        seg_o.axis[g].den  = vst_pkg::DenW'(1);
        seg_o.axis[g].fin  = 1'b0;
        seg_o.axis[g].neg  = 1'b0;
      end
    end
  end

endmodule

### design/vst_queue.sv
// Short queue of classified segments between the front and back ends.
module vst_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  vst_pkg::vst_seg_t wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              empty_o,
  output vst_pkg::vst_seg_t rdata_o
);

  localparam int unsigned PtrW = $clog2(vst_pkg::QueueDepth);

  vst_pkg::vst_seg_t mem_q [vst_pkg::QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == (PtrW+1)'(vst_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = do_wr ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### design/vst_back.sv
// Back end: forms the cross products of crossing times, then walks the grid cell by cell.
`include "voxel_segment_traversal_top_macros.svh"
module vst_back #(
  parameter int unsigned MAX_CELLS = vst_pkg::MaxCellsDef,
  parameter int unsigned FRAC_BITS = vst_pkg::FracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  vst_pkg::vst_seg_t q_data_i,
  output logic              q_rd_o,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       cell_x_o,
  output logic [15:0]       cell_y_o,
  output logic [15:0]       cell_z_o,
  output logic              last_o,
  output logic              truncated_o
);

  localparam int unsigned NW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned KW = $clog2(vst_pkg::MulSteps);

  vst_pkg::vst_state_e state_q, state_d;
  vst_pkg::vst_seg_t   seg_q;
  logic signed [vst_pkg::CellW-1:0] cell_q [3];
  logic signed [vst_pkg::CellW-1:0] cell_d [3];
  logic [vst_pkg::ProdW-1:0] p_q [6];
  logic [vst_pkg::ProdW-1:0] p_d [6];
  logic [KW-1:0] k_q, k_d;
  logic [NW-1:0] n_q, n_d;

  logic        ovalid_q, ovalid_d;
  logic [15:0] ox_q, oy_q, oz_q;
  logic        olast_q, otrunc_q;

  logic        fire, done, at_limit, load;
  logic [2:0]  pidx;
  logic [1:0]  ma, mb, ax;
  logic [vst_pkg::DenHalf-1:0] mden;
  logic [vst_pkg::NumW+vst_pkg::DenHalf-1:0] prod;
  logic        e01, e02, e12;
  logic [vst_pkg::ProdW-1:0] sh [3];

  assign empty       = !ovalid_q;
  assign cell_x_o    = ox_q;
  assign cell_y_o    = oy_q;
  assign cell_z_o    = oz_q;
  assign last_o      = olast_q;
  assign truncated_o = otrunc_q;

  assign fire     = (state_q == vst_pkg::ST_WALK) && (!ovalid_q || pop);
  assign done     = (cell_q[0] == '0) && (cell_q[1] == '0) && (cell_q[2] == '0);
  assign at_limit = (n_q == NW'(MAX_CELLS - 1));
  assign load     = (state_q == vst_pkg::ST_IDLE) && !q_empty_i;
  assign q_rd_o   = load;

  // One half-width partial product per cycle.
  assign pidx = 3'(k_q >> 1);
  assign ma   = vst_pkg::pair_a(pidx);
  assign mb   = vst_pkg::pair_b(pidx);
  assign mden = k_q[0] ? seg_q.axis[mb].den[vst_pkg::DenW-1:vst_pkg::DenHalf]
                       : seg_q.axis[mb].den[vst_pkg::DenHalf-1:0];
  assign prod = seg_q.axis[ma].num0 * mden;

  // Exact comparison of crossing times; an axis that never crosses never wins.
  assign e01 = seg_q.axis[0].fin && (!seg_q.axis[1].fin || p_q[vst_pkg::P01] < p_q[vst_pkg::P10]);
  assign e02 = seg_q.axis[0].fin && (!seg_q.axis[2].fin || p_q[vst_pkg::P02] < p_q[vst_pkg::P20]);
  assign e12 = seg_q.axis[1].fin && (!seg_q.axis[2].fin || p_q[vst_pkg::P12] < p_q[vst_pkg::P21]);

  always_comb begin
    priority if (e01 && e02) ax = 2'd0;
    else if (!e01 && e12)    ax = 2'd1;
    else                     ax = 2'd2;
  end

  for (genvar g = 0; g < 3; g++) begin : g_sh
    assign sh[g] = vst_pkg::ProdW'(seg_q.axis[g].den) << FRAC_BITS;
  end

  // Sequencer for product setup and the walk.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    n_d     = n_q;
    cell_d  = cell_q;
    p_d     = p_q;
    unique case (state_q)
      vst_pkg::ST_IDLE: begin
        if (load) begin
          state_d = vst_pkg::ST_MUL;
          k_d     = '0;
          n_d     = '0;
          for (int i = 0; i < 3; i++) begin
            cell_d[i] = q_data_i.axis[i].start_cell;
          end
        end
      end
      vst_pkg::ST_MUL: begin
        if (k_q[0]) begin
          p_d[pidx] = p_q[pidx] + (vst_pkg::ProdW'(prod) << vst_pkg::DenHalf);
        end else begin
          p_d[pidx] = vst_pkg::ProdW'(prod);
        end
        k_d = k_q + KW'(1);
        if (k_q == KW'(vst_pkg::MulSteps - 1)) begin
          state_d = vst_pkg::ST_WALK;
        end
      end
      vst_pkg::ST_WALK: begin
        if (fire) begin
          if (done || at_limit) begin
            state_d = vst_pkg::ST_IDLE;
          end else begin
            n_d = n_q + NW'(1);
            cell_d[ax] = seg_q.axis[ax].neg ? cell_q[ax] - vst_pkg::CellW'(1)
                                            : cell_q[ax] + vst_pkg::CellW'(1);
            unique case (ax)
              2'd0: begin
                p_d[vst_pkg::P01] = p_q[vst_pkg::P01] + sh[1];
                p_d[vst_pkg::P02] = p_q[vst_pkg::P02] + sh[2];
              end
              2'd1: begin
                p_d[vst_pkg::P10] = p_q[vst_pkg::P10] + sh[0];
                p_d[vst_pkg::P12] = p_q[vst_pkg::P12] + sh[2];
              end
              default: begin
                p_d[vst_pkg::P20] = p_q[vst_pkg::P20] + sh[0];
                p_d[vst_pkg::P21] = p_q[vst_pkg::P21] + sh[1];
              end
            endcase
          end
        end
      end
      default: state_d = vst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (fire) begin
      ovalid_d = 1'b1;
    end else if (pop) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vst_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    n_q    <= n_d;
    cell_q <= cell_d;
    p_q    <= p_d;
    if (load) begin
      seg_q <= q_data_i;
    end
    if (fire) begin
      ox_q     <= cell_q[0][15:0] + seg_q.axis[0].org;
      oy_q     <= cell_q[1][15:0] + seg_q.axis[1].org;
      oz_q     <= cell_q[2][15:0] + seg_q.axis[2].org;
      olast_q  <= done || at_limit;
      otrunc_q <= !done && at_limit;
    end
  end

  `VST_ASSERT_IMP(a_trunc_last, clk_i, rst_ni, ovalid_q && otrunc_q, olast_q, "truncated result without last")
  `VST_ASSERT_NXT(a_end_last, clk_i, rst_ni, fire && done, ovalid_q && olast_q, "end cell not marked last")
  `VST_ASSERT_NXT(a_end_idle, clk_i, rst_ni, fire && (done || at_limit), state_q == vst_pkg::ST_IDLE, "walk did not stop")
  `VST_ASSERT_NXT(a_mul_walk, clk_i, rst_ni, state_q == vst_pkg::ST_MUL && k_q == KW'(vst_pkg::MulSteps - 1), state_q == vst_pkg::ST_WALK, "setup overran")

endmodule
